### hw/rtl/shbi_pkg.sv
package shbi_pkg;

   localparam int BYTE_W = 8;
   localparam int HASH_W = 32;
   localparam int COUNT_W = 17;
   localparam int CAP_W = 20;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;

   // 31 * h is formed as (h << 5) - h.
   localparam int HASH_MULT_SHIFT = 5;

   localparam int PRIME_TABLE_STORED = 13;
   localparam int PRIME_TABLE_ENTRIES_DEF = 13;

   typedef logic [COUNT_W-1:0] prime_type;

   localparam prime_type PRIME_LIST [PRIME_TABLE_STORED] = '{
      17'd17, 17'd37, 17'd79, 17'd163, 17'd331, 17'd673, 17'd1361, 17'd2729,
      17'd5471, 17'd10949, 17'd21911, 17'd43853, 17'd87719
   };

   typedef struct packed {
      logic start;
   } mod_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

endpackage

### hw/rtl/shbi_prime_select.sv
module shbi_prime_select #(
   parameter int PRIME_TABLE_ENTRIES = shbi_pkg::PRIME_TABLE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [shbi_pkg::CAP_W-1:0] csr_wdata,
   output shbi_pkg::prime_type        chosen_prime
);
   import shbi_pkg::*;

   localparam int USABLE = (PRIME_TABLE_ENTRIES < 1) ? 1 :
                           (PRIME_TABLE_ENTRIES > PRIME_TABLE_STORED) ?
                           PRIME_TABLE_STORED : PRIME_TABLE_ENTRIES;

   prime_type prime_ff;
   prime_type prime_in;
   prime_type pick;

   // Walk the table from the top down so the lowest entry that fits wins.
   always_comb begin
      pick = PRIME_LIST[USABLE-1];
      for (int i = USABLE - 1; i >= 0; i--) begin
         if ({{(CAP_W-COUNT_W){1'b0}}, PRIME_LIST[i]} >= csr_wdata) begin
            pick = PRIME_LIST[i];
         end
      end
   end

   assign prime_in = csr_we ? pick : prime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= PRIME_LIST[0];
      end else begin
         prime_ff <= prime_in;
      end
   end

   assign chosen_prime = prime_ff;

endmodule

### hw/rtl/shbi_mod_unit.sv
module shbi_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  shbi_pkg::mod_ctrl_type      ctrl,
   input  logic [shbi_pkg::HASH_W-1:0] dividend,
   input  shbi_pkg::prime_type         divisor,
   output shbi_pkg::mod_stat_type      stat,
   output shbi_pkg::prime_type         remainder
);
   import shbi_pkg::*;

   localparam int CNT_W = $clog2(HASH_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HASH_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   prime_type        div_ff, div_in;
   prime_type        rem_ff, rem_in;

   logic [COUNT_W:0] rem_shift;
   logic [COUNT_W:0] div_ext;
   logic [COUNT_W:0] rem_sub;

   // One restoring step per cycle: shift in the next dividend bit, then
   // subtract the divisor when it fits.
   assign rem_shift = {rem_ff, dvd_ff[HASH_W-1]};
   assign div_ext = {1'b0, div_ff};
   assign rem_sub = rem_shift - div_ext;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in = '0;
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         rem_in = (rem_shift >= div_ext) ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("modulo start while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start && cnt_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("modulo did not finish after last step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

endmodule

### hw/rtl/string_hash_bucket_index_top.sv
// A request with a nonzero key byte is absorbed into the running hash.
// A zero key byte starts a 32-step restoring modulo; its response is loaded
// once the modulo is done and the response slot is free.
// Throughput: one key byte per cycle, held off from a terminator until its response loads.
// Reset: synchronous, clears the running hash and the response valid, and selects 17.
module string_hash_bucket_index_top #(
   parameter int PRIME_TABLE_ENTRIES = shbi_pkg::PRIME_TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key_byte [7:0]
   input  logic [shbi_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hash_value [31:0], bucket_index [48:32], bucket_count [65:49], zero [71:66]
   output logic [shbi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [shbi_pkg::CAP_W-1:0]      csr_wdata
);
   import shbi_pkg::*;

   typedef enum logic [1:0] {
      ST_HASH = 2'b01,
      ST_MOD  = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [HASH_W-1:0] mag_ff, mag_in;
   prime_type   count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   prime_type   rsp_index_ff, rsp_index_in;
   prime_type   rsp_count_ff, rsp_count_in;

   prime_type    chosen_prime;
   mod_ctrl_type mod_ctrl;
   mod_stat_type mod_stat;
   prime_type    remainder;

   logic [BYTE_W-1:0] key_byte;
   logic              accept;
   logic              is_term;
   logic [HASH_W-1:0] hash_mag;
   logic              load_rsp;

   shbi_prime_select #(
      .PRIME_TABLE_ENTRIES(PRIME_TABLE_ENTRIES)
   ) u_prime_select (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .chosen_prime(chosen_prime)
   );

   shbi_mod_unit u_mod_unit (
      .clock(clock),
      .reset(reset),
      .ctrl(mod_ctrl),
      .dividend(hash_mag),
      .divisor(chosen_prime),
      .stat(mod_stat),
      .remainder(remainder)
   );

   assign key_byte = req_tdata[BYTE_W-1:0];
   assign req_tready = (state_ff == ST_HASH);
   assign accept = req_tvalid && req_tready;
   assign is_term = (key_byte == '0);

   // The magnitude is read as unsigned, so the most negative hash gives 2^31.
   assign hash_mag = hash_ff[HASH_W-1] ? (HASH_W'(0) - hash_ff) : hash_ff;

   assign mod_ctrl.start = accept && is_term;
   assign load_rsp = (state_ff == ST_MOD) && mod_stat.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      mag_in = mag_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_HASH: begin
            if (accept) begin
               if (is_term) begin
                  mag_in = hash_mag;
                  count_in = chosen_prime;
                  hash_in = '0;
                  state_in = ST_MOD;
               end else begin
                  hash_in = (hash_ff << HASH_MULT_SHIFT) - hash_ff
                            + {{(HASH_W-BYTE_W){1'b0}}, key_byte};
               end
            end
         end
         ST_MOD: begin
            if (load_rsp) begin
               state_in = ST_HASH;
            end
         end
         default: begin
            state_in = ST_HASH;
         end
      endcase
   end

   always_comb begin
      rsp_hash_in = rsp_hash_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in = mag_ff;
         rsp_index_in = remainder;
         rsp_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HASH;
         hash_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      count_ff <= count_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-HASH_W-2*COUNT_W){1'b0}},
                       rsp_count_ff, rsp_index_ff, rsp_hash_ff};

   a_no_req_during_mod: assert property (@(posedge clock) disable iff (reset)
      mod_stat.busy |-> (state_ff == ST_MOD))
      else $error("modulo running while requests are taken");

   a_rsp_index_bound: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_tvalid && rsp_index_ff < rsp_count_ff))
      else $error("response bucket index not below bucket count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response changed while waiting");

endmodule

### bench/tb.sv
module tb;
   import shbi_pkg::*;

   localparam logic [7:0] KEY_END = 8'd0;
   localparam int TABLE_USED = 13;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_PRINTED = 40;

   localparam logic [COUNT_W-1:0] BUCKET_PRIMES [TABLE_USED] = '{
      17'd17, 17'd37, 17'd79, 17'd163, 17'd331, 17'd673, 17'd1361, 17'd2729,
      17'd5471, 17'd10949, 17'd21911, 17'd43853, 17'd87719
   };

   typedef logic [BYTE_W-1:0] key_byte_type;

   typedef struct packed {
      logic [HASH_W-1:0]  hash_value;
      logic [COUNT_W-1:0] bucket_index;
      logic [COUNT_W-1:0] bucket_count;
   } bucket_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CAP_W-1:0]      csr_wdata = '0;

   key_byte_type      key_queue [$];
   bucket_result_type pending_results [$];

   logic [HASH_W-1:0]  hash_state = '0;
   logic [COUNT_W-1:0] model_prime = 17'd17;

   bit idle_on = 1'b1;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;
   int stall_left = 0;
   int send_gap = 0;

   int errors = 0;
   int bytes_accepted = 0;
   int responses_checked = 0;
   int settings_written = 0;

   string_hash_bucket_index_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] prime_for_capacity(input logic [CAP_W-1:0] want);
      for (int i = 0; i < TABLE_USED; i++) begin
         if (BUCKET_PRIMES[i] >= want) return BUCKET_PRIMES[i];
      end
      return BUCKET_PRIMES[TABLE_USED-1];
   endfunction

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
   endtask

   // Driver: a new request is presented only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (key_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= key_queue.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold whenever the stimulus asks for one.
   always @(posedge clock) begin : receiver
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall = pick_gap();
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= stall - 1;
         end
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted response.
   always @(posedge clock) begin : monitor
      logic [HASH_W-1:0] magnitude;
      bucket_result_type got;
      bucket_result_type want;
      if (reset) begin
         hash_state = '0;
         model_prime = prime_for_capacity('0);
      end else begin
         if (csr_we) model_prime = prime_for_capacity(csr_wdata);
         if (req_tvalid && req_tready) begin
            bytes_accepted++;
            if (req_tdata != KEY_END) begin
               hash_state = hash_state * 32'd31 + {24'd0, req_tdata};
            end else begin
               magnitude = hash_state[HASH_W-1] ? -hash_state : hash_state;
               want.hash_value = magnitude;
               want.bucket_index = COUNT_W'(magnitude % {15'd0, model_prime});
               want.bucket_count = model_prime;
               pending_results.push_back(want);
               hash_state = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hash_value = rsp_tdata[31:0];
            got.bucket_index = rsp_tdata[48:32];
            got.bucket_count = rsp_tdata[65:49];
            if (rsp_tdata[71:66] != '0)
               report_mismatch("padding", rsp_tdata[71:66], 0);
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response, hash_value", got.hash_value, -1);
            end else begin
               want = pending_results.pop_front();
               responses_checked++;
               if (got.hash_value != want.hash_value)
                  report_mismatch("hash_value", got.hash_value, want.hash_value);
               if (got.bucket_index != want.bucket_index)
                  report_mismatch("bucket_index", got.bucket_index, want.bucket_index);
               if (got.bucket_count != want.bucket_count)
                  report_mismatch("bucket_count", got.bucket_count, want.bucket_count);
            end
         end
      end
   end

   // Sampled on the falling edge so that the clocked processes have settled.
   task automatic wait_until_drained(input int limit);
      int waited;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while ((key_queue.size() > 0 || req_tvalid || pending_results.size() > 0)
                 && waited < limit);
   endtask

   // Nonzero bytes give no response, so the block gets time to finish before the write.
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_until_drained(1000000);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_written++;
   endtask

   // Digits 1..31 in bijective base 31 give a key whose hash is exactly the target.
   task automatic queue_key_with_hash(input longint target);
      key_byte_type digits [$];
      longint n;
      int d;
      n = target;
      while (n > 0) begin
         d = int'(n % 31);
         if (d == 0) d = 31;
         digits.push_front(key_byte_type'(d));
         n = (n - d) / 31;
      end
      foreach (digits[i]) key_queue.push_back(digits[i]);
      key_queue.push_back(KEY_END);
   endtask

   task automatic queue_random_keys(input int n_items);
      int added;
      int len;
      int style;
      int r;
      added = 0;
      while (added < n_items) begin
         style = $urandom_range(0, 9);
         if (style == 0) len = 0;
         else if (style == 1) len = $urandom_range(20, 60);
         else len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            if (style == 2) begin
               r = $urandom_range(0, 3);
               key_queue.push_back(r == 0 ? 8'h01 : r == 1 ? 8'hff : r == 2 ? 8'h80 : 8'h7f);
            end else begin
               key_queue.push_back(key_byte_type'($urandom_range(1, 255)));
            end
         end
         key_queue.push_back(KEY_END);
         added += len + 1;
      end
   endtask

   initial begin
      logic [CAP_W-1:0] settings [$];
      settings = '{20'd1, 20'd17, 20'd18, 20'd5471, 20'd5472, 20'd87719, 20'd87720,
                   20'hfffff, 20'd0};
      settings.push_back(CAP_W'($urandom_range(0, 87720)));
      settings.push_back(CAP_W'($urandom_range(0, 400)));
      settings.push_back(CAP_W'($urandom()));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed keys under the reset bucket count: empty key, single extreme bytes,
      // and keys that land on the most negative hash and on minus one.
      key_queue.push_back(KEY_END);
      key_queue.push_back(8'hff);
      key_queue.push_back(KEY_END);
      key_queue.push_back(8'h01);
      key_queue.push_back(KEY_END);
      queue_key_with_hash(64'h8000_0000);
      queue_key_with_hash(64'hffff_ffff);

      foreach (settings[i]) begin
         set_capacity(settings[i]);
         idle_on = ($urandom_range(0, 3) != 0);
         queue_random_keys(70);
         if (i == 2) begin
            // Keep requests coming while responses are held back so the block backs up.
            idle_on = 1'b0;
            queue_random_keys(60);
            @(negedge clock);
            holds_asked++;
         end
      end

      wait_until_drained(200000);
      repeat (SETTLE_CYCLES) @(posedge clock);
      foreach (pending_results[i])
         report_mismatch("missing response, hash_value", -1, pending_results[i].hash_value);

      $display("Run covered %0d key bytes and %0d checked responses across %0d capacity settings.",
               bytes_accepted, responses_checked, settings_written);
      $display("It included extreme capacities, empty and long keys, and a long output stall.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/shbi_pkg.sv
hw/rtl/shbi_prime_select.sv
hw/rtl/shbi_mod_unit.sv
hw/rtl/string_hash_bucket_index_top.sv
bench/tb.sv
